### design/bzs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzs_pkg
// Shared types and constants for the cubic Bezier split-at-parameter block.
// ----------------------------------------------------------------------------
package bzs_pkg;

   localparam int MAX_POINTS_DEF  = 65536;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   // status codes reported with end_of_curve
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_AT_START = 2'd1;
   localparam logic [1:0] ST_AT_END   = 2'd2;
   localparam logic [1:0] ST_MISSING  = 2'd3;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic [15:0]        seg_start;
      logic [16:0]        split_t;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic               half;
      logic               end_of_curve;
      logic               run_last;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } point_type;

   // work orders handed from the front to the back
   typedef enum logic [2:0] {
      CMD_PASS,    // emit the point as is
      CMD_STORE0,  // store segment start point and emit it
      CMD_STORE,   // store inner point; dump buffer if curve ends here
      CMD_END,     // split at 1.0 on the curve's last point
      CMD_SPLIT    // full de Casteljau split
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      point_type  pt;
      logic       half;
      logic       last;
      logic [1:0] status;
      logic [1:0] slot;
   } entry_type;

endpackage

### design/bzs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzs_fifo
// Small register queue that decouples the classifier from the executor.
// ----------------------------------------------------------------------------
module bzs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNTW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("queue pop while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop && !full) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");

endmodule

### design/bzs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzs_front
// Counts points of the curve and classifies each against the split segment.
// ----------------------------------------------------------------------------
module bzs_front
   import bzs_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  req_type              in_data,
   output logic                 push,
   output entry_type            push_entry,
   output logic [FRAC_BITS:0]   push_t,
   input  logic                 queue_full
);

   localparam int CW   = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int PW   = FRAC_BITS + 1;
   localparam int TW   = (PW > 17) ? PW : 17;
   localparam int CMPW = ((CW > 17) ? CW : 17) + 1;
   localparam logic [TW-1:0] ONE_W = TW'(1) << FRAC_BITS;

   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   start_ff, start_in;
   logic [PW-1:0] param_ff, param_in;
   logic          done_ff, done_in;

   logic            accept, first, no_split, at_one;
   logic [TW-1:0]   t_wide;
   logic [15:0]     start_cur;
   logic [PW-1:0]   param_cur;
   logic [CMPW-1:0] n_w, s_w, rel;
   entry_type       entry;

   assign in_ready = !queue_full;
   assign accept   = in_valid && !queue_full;

   always_comb begin
      first     = (count_ff == '0);
      t_wide    = TW'(in_data.split_t);
      start_cur = first ? in_data.seg_start : start_ff;
      param_cur = param_ff;
      if (first) begin
         param_cur = (t_wide > ONE_W) ? PW'(ONE_W) : PW'(t_wide);
      end
      no_split = (start_cur == '0) && (param_cur == '0);
      at_one   = (param_cur == PW'(ONE_W));
      n_w      = CMPW'(count_ff);
      s_w      = CMPW'(start_cur);
      rel      = n_w - s_w;

      entry.cmd    = CMD_PASS;
      entry.pt.x   = in_data.point_x;
      entry.pt.y   = in_data.point_y;
      entry.half   = 1'b0;
      entry.last   = in_data.last_point;
      entry.status = ST_MISSING;
      entry.slot   = rel[1:0];

      if (no_split) begin
         entry.status = ST_AT_START;
      end else if (done_ff) begin
         entry.half   = 1'b1;
         entry.status = ST_OK;
      end else if (n_w < s_w) begin
         entry.cmd = CMD_PASS;
      end else if (n_w == s_w) begin
         entry.cmd = CMD_STORE0;
      end else if (n_w < s_w + CMPW'(3)) begin
         entry.cmd = CMD_STORE;
      end else if (n_w == s_w + CMPW'(3)) begin
         if (in_data.last_point && at_one) begin
            entry.cmd    = CMD_END;
            entry.status = ST_AT_END;
         end else begin
            entry.cmd    = CMD_SPLIT;
            entry.status = ST_OK;
         end
      end else begin
         entry.half   = 1'b1;
         entry.status = ST_OK;
      end

      count_in = count_ff;
      start_in = start_ff;
      param_in = param_ff;
      done_in  = done_ff;
      if (accept) begin
         start_in = start_cur;
         param_in = param_cur;
         if (in_data.last_point) begin
            count_in = '0;
            done_in  = 1'b0;
         end else begin
            if (count_ff < CW'(MAX_POINTS - 1)) begin
               count_in = count_ff + 1'b1;
            end
            if (entry.cmd == CMD_SPLIT) begin
               done_in = 1'b1;
            end
         end
      end
   end

   assign push       = accept;
   assign push_entry = entry;
   assign push_t     = param_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         start_ff <= '0;
         param_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         start_ff <= start_in;
         param_ff <= param_in;
         done_ff  <= done_in;
      end
   end

endmodule

### design/bzs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzs_back
// Executes queued work: pass-through, segment buffering and the split,
// driving the registered result channel.
// ----------------------------------------------------------------------------
module bzs_back
   import bzs_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  entry_type          q_entry,
   input  logic [FRAC_BITS:0] q_t,
   output logic               q_pop,
   output logic               out_valid,
   input  logic               out_ready,
   output rsp_type            out_data
);

   localparam int PW  = FRAC_BITS + 1;
   localparam int PRW = 33 + PW + 1;
   localparam logic signed [PRW-1:0] RND = PRW'(1) << (FRAC_BITS - 1);

   typedef enum logic [2:0] {S_IDLE, S_DUMP, S_MUL, S_ADD, S_EMIT} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;

   entry_type     cur_ff, cur_in;
   logic [PW-1:0] t_ff, t_in;
   point_type     buf0_ff, buf0_in, buf1_ff, buf1_in, buf2_ff, buf2_in;
   point_type     a_ff, a_in, b_ff, b_in, c_ff, c_in;
   point_type     d_ff, d_in, e_ff, e_in, m_ff, m_in;
   point_type     base_ff, base_in;
   logic signed [PRW-1:0] prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic [1:0]    idx_ff, idx_in, end_ff, end_in;
   logic [2:0]    step_ff, step_in;

   logic                  out_free, fin;
   point_type             op_a, op_b, sel_pt, lerp_res;
   logic signed [32:0]    diff_x, diff_y;
   logic signed [PW:0]    t_s;
   logic signed [PRW-1:0] biased_x, biased_y, shift_x, shift_y;

   function automatic rsp_type make_rsp(point_type p, logic h, logic eoc, logic rl,
                                        logic [1:0] st);
      rsp_type r;
      r.out_x        = p.x;
      r.out_y        = p.y;
      r.half         = h;
      r.end_of_curve = eoc;
      r.run_last     = rl;
      r.status       = eoc ? st : ST_OK;
      return r;
   endfunction

   // operand select for the shared lerp lanes
   always_comb begin
      case (step_ff)
         3'd0:    begin op_a = buf0_ff; op_b = buf1_ff;   end
         3'd1:    begin op_a = buf1_ff; op_b = buf2_ff;   end
         3'd2:    begin op_a = buf2_ff; op_b = cur_ff.pt; end
         3'd3:    begin op_a = a_ff;    op_b = b_ff;      end
         3'd4:    begin op_a = b_ff;    op_b = c_ff;      end
         default: begin op_a = d_ff;    op_b = e_ff;      end
      endcase
   end

   assign diff_x = {op_b.x[31], op_b.x} - {op_a.x[31], op_a.x};
   assign diff_y = {op_b.y[31], op_b.y} - {op_a.y[31], op_a.y};
   assign t_s    = $signed({1'b0, t_ff});

   // round half up: floor((prod + half) / 2^FRAC_BITS), then add the base
   assign biased_x   = prod_x_ff + RND;
   assign biased_y   = prod_y_ff + RND;
   assign shift_x    = biased_x >>> FRAC_BITS;
   assign shift_y    = biased_y >>> FRAC_BITS;
   assign lerp_res.x = base_ff.x + shift_x[31:0];
   assign lerp_res.y = base_ff.y + shift_y[31:0];

   assign out_free = !rsp_valid_ff || out_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      rsp_in       = rsp_ff;
      cur_in       = cur_ff;
      t_in         = t_ff;
      buf0_in      = buf0_ff;
      buf1_in      = buf1_ff;
      buf2_in      = buf2_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      m_in         = m_ff;
      base_in      = base_ff;
      prod_x_in    = prod_x_ff;
      prod_y_in    = prod_y_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      step_in      = step_ff;
      q_pop        = 1'b0;
      fin          = 1'b0;
      sel_pt       = cur_ff.pt;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop  = 1'b1;
               cur_in = q_entry;
               t_in   = q_t;
               unique case (q_entry.cmd)
                  CMD_PASS: begin
                     rsp_valid_in = 1'b1;
                     rsp_in = make_rsp(q_entry.pt, q_entry.half, q_entry.last, 1'b1,
                                       q_entry.status);
                  end
                  CMD_STORE0: begin
                     buf0_in      = q_entry.pt;
                     rsp_valid_in = 1'b1;
                     rsp_in = make_rsp(q_entry.pt, 1'b0, q_entry.last, 1'b1,
                                       q_entry.status);
                  end
                  CMD_STORE: begin
                     if (q_entry.slot == 2'd2) begin
                        buf2_in = q_entry.pt;
                     end else begin
                        buf1_in = q_entry.pt;
                     end
                     if (q_entry.last) begin
                        idx_in   = 2'd1;
                        end_in   = q_entry.slot;
                        state_in = S_DUMP;
                     end
                  end
                  CMD_END: begin
                     idx_in   = 2'd1;
                     end_in   = 2'd3;
                     state_in = S_DUMP;
                  end
                  CMD_SPLIT: begin
                     step_in  = '0;
                     state_in = S_MUL;
                  end
                  default: ;
               endcase
            end
         end
         S_DUMP: begin
            if (out_free) begin
               fin = (idx_ff == end_ff);
               if (fin) begin
                  sel_pt = cur_ff.pt;
               end else if (idx_ff == 2'd1) begin
                  sel_pt = buf1_ff;
               end else begin
                  sel_pt = buf2_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_in = make_rsp(sel_pt, 1'b0, fin && cur_ff.last, fin, cur_ff.status);
               idx_in = idx_ff + 1'b1;
               if (fin) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_MUL: begin
            prod_x_in = diff_x * t_s;
            prod_y_in = diff_y * t_s;
            base_in   = op_a;
            state_in  = S_ADD;
         end
         S_ADD: begin
            case (step_ff)
               3'd0:    a_in = lerp_res;
               3'd1:    b_in = lerp_res;
               3'd2:    c_in = lerp_res;
               3'd3:    d_in = lerp_res;
               3'd4:    e_in = lerp_res;
               default: m_in = lerp_res;
            endcase
            if (step_ff == 3'd5) begin
               step_in  = '0;
               state_in = S_EMIT;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               fin = (step_ff == 3'd6);
               rsp_valid_in = 1'b1;
               case (step_ff)
                  3'd0:    rsp_in = make_rsp(a_ff, 1'b0, 1'b0, 1'b0, ST_OK);
                  3'd1:    rsp_in = make_rsp(d_ff, 1'b0, 1'b0, 1'b0, ST_OK);
                  3'd2:    rsp_in = make_rsp(m_ff, 1'b0, 1'b0, 1'b0, ST_OK);
                  3'd3:    rsp_in = make_rsp(m_ff, 1'b1, 1'b0, 1'b0, ST_OK);
                  3'd4:    rsp_in = make_rsp(e_ff, 1'b1, 1'b0, 1'b0, ST_OK);
                  3'd5:    rsp_in = make_rsp(c_ff, 1'b1, 1'b0, 1'b0, ST_OK);
                  default: rsp_in = make_rsp(cur_ff.pt, 1'b1, cur_ff.last, 1'b1,
                                             cur_ff.status);
               endcase
               step_in = step_ff + 1'b1;
               if (fin) begin
                  step_in  = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
      rsp_ff    <= rsp_in;
      cur_ff    <= cur_in;
      t_ff      <= t_in;
      buf0_ff   <= buf0_in;
      buf1_ff   <= buf1_in;
      buf2_ff   <= buf2_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      d_ff      <= d_in;
      e_ff      <= e_in;
      m_ff      <= m_in;
      base_ff   <= base_in;
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      idx_ff    <= idx_in;
      end_ff    <= end_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE))
      else $error("queue popped while busy");

   a_emit_last_marks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && step_ff == 3'd6 && out_free) |=>
         (out_valid && out_data.run_last && out_data.half))
      else $error("split did not close with run_last on half 1");

   a_split_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD && step_ff != 3'd5) |=> (state_ff == S_MUL))
      else $error("lerp sequence broken");

endmodule

### design/cubic_bezier_split_at_param.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_split_at_param
// Streams control points of a cubic Bezier curve and splits one segment at
// parameter t by de Casteljau subdivision.
// ----------------------------------------------------------------------------
// A pass-through point is registered in the queue, then in the result register.
// Throughput: one transaction per cycle for points with at most one result, while the
// back end is idle and rsp_ready is high. The closing point of the split segment holds
// the back end to pop it, run six two-lane lerps (multiply, then round and add) and
// emit seven results; the queue keeps accepting while it has room.
// Reset clears the point counter, held parameters, queue and result channel.
// ----------------------------------------------------------------------------
module cubic_bezier_split_at_param
   import bzs_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int QW = $bits(entry_type) + FRAC_BITS + 1;

   // front to queue
   logic               push, queue_full;
   entry_type          push_entry;
   logic [FRAC_BITS:0] push_t;

   // queue to back
   logic               pop, q_valid;
   logic [QW-1:0]      q_word;
   entry_type          q_entry;
   logic [FRAC_BITS:0] q_t;

   // Classify each transaction against the segment window and tag it with
   // the work the back end has to do.
   bzs_front #(
      .MAX_POINTS (MAX_POINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_data    (req_data),
      .push       (push),
      .push_entry (push_entry),
      .push_t     (push_t),
      .queue_full (queue_full)
   );

   // Carry the split parameter alongside each entry so a new curve can start
   // in the front while the back still works on the previous split.
   bzs_fifo #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH_DEF)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_t, push_entry}),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (q_word),
      .not_empty (q_valid)
   );

   assign q_entry = q_word[$bits(entry_type)-1:0];
   assign q_t     = q_word[QW-1:$bits(entry_type)];

   // Hold the segment buffer, run the lerps and drive the result register.
   bzs_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_t       (q_t),
      .q_pop     (pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule
